FILE: design/can_latest_frame_table_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the latest frame table
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef CAN_LATEST_FRAME_TABLE_MACROS_SVH
`define CAN_LATEST_FRAME_TABLE_MACROS_SVH

// condition holds at every edge
`define CLFT_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("clft: invariant violated");

// consequent holds in the same cycle as the antecedent
`define CLFT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clft: implication violated");

// consequent holds in the cycle after the antecedent
`define CLFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clft: next-cycle check violated");

`endif

FILE: design/clft_pkg.sv
// ---------------------------------------------------------------------------
// clft_pkg
// Word types, command codes and key layout for the latest frame table.
// ---------------------------------------------------------------------------
package clft_pkg;

  localparam int KEY_W = 39;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic        command;
    logic [7:0]  slot_select;
    logic [7:0]  bus;
    logic        extended;
    logic        remote;
    logic [28:0] ident;
    logic [3:0]  length_code;
    logic [63:0] payload;
    logic [63:0] stamp_us;
    logic [7:0]  record_seq;
  } req_t;

  typedef struct packed {
    logic [7:0]       slot_used;
    logic             hit;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [8:0]       keys_held;
    logic [31:0]      dropped_total;
    logic             entry_valid;
    logic [KEY_W-1:0] entry_key;
    logic [63:0]      entry_stamp;
    logic [63:0]      entry_payload;
    logic [3:0]       entry_length;
    logic [7:0]       entry_seq;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [63:0]      stamp;
    logic [63:0]      payload;
    logic [3:0]       length;
    logic [7:0]       seq;
  } entry_t;

endpackage

FILE: design/can_latest_frame_table.sv
// ---------------------------------------------------------------------------
// can_latest_frame_table
// Latest CAN frame per key, with oldest-timestamp eviction when full.
//
// Input words arrive on req (req_valid / req_stall), result words leave on
// rsp (rsp_valid / rsp_stall); every input word yields one result word.
// An update scans the occupied slots through the single read port of the
// slot memory, one slot per cycle, matching the key and tracking the oldest
// entry in the same pass. The scan is followed by the DRAIN, WRITE and FINISH
// states; FINISH loads the result into the output register and returns to
// IDLE, where the next word is taken. An update on an empty table skips the
// scan and goes straight to WRITE. A read passes through READ and FINISH.
// One word is in work at a time; req_stall is high until the result is
// loaded into the output register, which can hold a word while the next
// input is taken. When rsp_stall is high the result stays in place and a
// finished word waits in the sequencer until the register frees up.
// Slots fill from 0 upward and never free, so a fill count marks the valid
// slots: reset empties the table at once, with no clearing pass.
// ---------------------------------------------------------------------------
`include "can_latest_frame_table_macros.svh"

module can_latest_frame_table #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  clft_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output clft_pkg::rsp_t rsp
);
  import clft_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [5:0] {
    IDLE   = 6'b000001,
    SCAN   = 6'b000010,
    DRAIN  = 6'b000100,
    WRITE  = 6'b001000,
    READ   = 6'b010000,
    FINISH = 6'b100000
  } state_t;

  state_t           state;
  req_t             req_q;
  rsp_t             res;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [31:0]      drop;
  logic [31:0]      drop_next;
  logic [IW-1:0]    ptr;
  logic             chk_on;
  logic [IW-1:0]    chk_idx;
  logic             hit_found;
  logic [IW-1:0]    hit_idx;
  logic [IW-1:0]    best_idx;
  logic [63:0]      best_stamp;
  logic [KEY_W-1:0] best_key;

  entry_t           mem [TABLE_ENTRIES];
  entry_t           rd_q;
  entry_t           wr_data;
  logic [IW-1:0]    rd_addr;
  logic             mem_we;

  logic [KEY_W-1:0] req_key;
  logic [IW-1:0]    target;
  logic             full;
  logic             scan_last;
  logic             older;
  logic             sel_ok;
  logic             rsp_free;

  always_comb begin
    req_key   = {req_q.bus, req_q.extended, req_q.remote, req_q.ident};
    full      = (count == CW'(TABLE_ENTRIES));
    scan_last = (ptr == IW'(count - CW'(1)));
    older     = (chk_idx == '0) || (rd_q.stamp < best_stamp) ||
                ((rd_q.stamp == best_stamp) && (rd_q.key < best_key));
    sel_ok    = (32'(req_q.slot_select) < 32'(count));
    rsp_free  = !rsp_valid || !rsp_stall;
    priority if (hit_found) begin
      target = hit_idx;
    end else if (!full) begin
      target = IW'(count);
    end else begin
      target = best_idx;
    end
    count_next = (hit_found || full) ? count : count + CW'(1);
    drop_next  = (!hit_found && full && (drop != '1)) ? drop + 32'd1 : drop;
    if (state == IDLE) begin
      rd_addr = IW'(req.slot_select);
    end else begin
      rd_addr = ptr;
    end
    mem_we  = (state == WRITE);
    wr_data = '{key: req_key, stamp: req_q.stamp_us, payload: req_q.payload,
                length: req_q.length_code, seq: req_q.record_seq};
  end

  assign req_stall = (state != IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[target] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      drop      <= '0;
      rsp_valid <= 1'b0;
      chk_on    <= 1'b0;
      hit_found <= 1'b0;
    end else begin
      if ((state == FINISH) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      chk_on  <= (state == SCAN);
      chk_idx <= ptr;
      if (chk_on) begin
        if (!hit_found && (rd_q.key == req_key)) begin
          hit_found <= 1'b1;
          hit_idx   <= chk_idx;
        end
        if (older) begin
          best_idx   <= chk_idx;
          best_stamp <= rd_q.stamp;
          best_key   <= rd_q.key;
        end
      end
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            req_q     <= req;
            ptr       <= '0;
            hit_found <= 1'b0;
            if (req.command == CMD_READ) begin
              state <= READ;
            end else if (count == '0) begin
              state <= WRITE;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          ptr <= ptr + IW'(1);
          if (scan_last) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= WRITE;
        end
        WRITE: begin
          count <= count_next;
          drop  <= drop_next;
          res   <= '{slot_used:     8'(target),
                     hit:           hit_found,
                     evicted:       !hit_found && full,
                     evicted_key:   (!hit_found && full) ? best_key : '0,
                     keys_held:     9'(count_next),
                     dropped_total: drop_next,
                     entry_valid:   1'b0,
                     entry_key:     '0,
                     entry_stamp:   '0,
                     entry_payload: '0,
                     entry_length:  '0,
                     entry_seq:     '0};
          state <= FINISH;
        end
        READ: begin
          res   <= '{slot_used:     req_q.slot_select,
                     hit:           1'b0,
                     evicted:       1'b0,
                     evicted_key:   '0,
                     keys_held:     9'(count),
                     dropped_total: drop,
                     entry_valid:   sel_ok,
                     entry_key:     sel_ok ? rd_q.key : '0,
                     entry_stamp:   sel_ok ? rd_q.stamp : '0,
                     entry_payload: sel_ok ? rd_q.payload : '0,
                     entry_length:  sel_ok ? rd_q.length : '0,
                     entry_seq:     sel_ok ? rd_q.seq : '0};
          state <= FINISH;
        end
        FINISH: begin
          if (rsp_free) begin
            rsp   <= res;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `CLFT_ASSERT_HOLDS(a_count_bound, count <= CW'(TABLE_ENTRIES))
  `CLFT_ASSERT_IMP(a_hit_xor_evict, rsp_valid, !(rsp.hit && rsp.evicted))
  `CLFT_ASSERT_IMP(a_evict_when_full, rsp_valid && rsp.evicted, full)
  `CLFT_ASSERT_NEXT(a_drop_monotonic, !rst, drop >= $past(drop))

endmodule
